// ----- hw/rtl/multi_key_timer_debouncer_defines.svh -----
// Assertion macros used by the debouncer RTL.
`ifndef MULTI_KEY_TIMER_DEBOUNCER_DEFINES_SVH
`define MULTI_KEY_TIMER_DEBOUNCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MKTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("debouncer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MKTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("debouncer assertion failed");

`endif

// ----- hw/rtl/mktd_pkg.sv -----
`timescale 1ns / 1ps

package mktd_pkg;

    localparam int KEYS     = 4;
    localparam int IO_KEYS  = 4;
    localparam int CNT_W    = 16;
    localparam int STATES_W = 2 * IO_KEYS;

    localparam logic [CNT_W-1:0] SETTLE_RESET  = 16'd2;
    localparam logic [CNT_W-1:0] RECHECK_RESET = 16'd10;

    typedef enum logic [1:0] {
        KEY_PRESSED = 2'd0,
        KEY_UP      = 2'd1,
        KEY_UNSURE  = 2'd2
    } t_key_state;

    typedef enum logic {
        REG_SETTLE  = 1'b0,
        REG_RECHECK = 1'b1
    } t_cfg_index;

    function automatic logic [CNT_W-1:0] eff_delay(input logic [CNT_W-1:0] d);
        eff_delay = (d == '0) ? CNT_W'(1) : d;
    endfunction

endpackage

// ----- hw/rtl/multi_key_timer_debouncer.sv -----
`timescale 1ns / 1ps
`include "multi_key_timer_debouncer_defines.svh"

// Channel | Handshake                      | Payload
// --------+--------------------------------+----------------------------------------------
// tick in | i_in_valid / o_in_ready        | i_pin_levels, i_falling_edges, i_read_strobe
// result  | o_out_valid / i_out_ready      | o_key_states, o_led_lines, o_press_pending
// config  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// The key state and the result register load at the same edge when a tick is accepted.
// One tick is accepted per cycle while the result register is empty or being drained.
// A stalled result holds the input off only until the result transaction completes.
// Synchronous active-low reset sets all keys up, timers idle, delays to 2 and 10.
// Configuration writes are always accepted.

module multi_key_timer_debouncer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mktd_pkg::IO_KEYS-1:0]  i_pin_levels,
    input  logic [mktd_pkg::IO_KEYS-1:0]  i_falling_edges,
    input  logic                          i_read_strobe,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mktd_pkg::STATES_W-1:0] o_key_states,
    output logic [mktd_pkg::IO_KEYS-1:0]  o_led_lines,
    output logic                          o_press_pending,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  mktd_pkg::t_cfg_index          i_cfg_index,
    input  logic [mktd_pkg::CNT_W-1:0]    i_cfg_data
);
    import mktd_pkg::*;

    logic [CNT_W-1:0]          r_settle;
    logic [CNT_W-1:0]          r_recheck;
    t_key_state                r_state [KEYS];
    logic [CNT_W-1:0]          r_count [KEYS];
    logic [KEYS-1:0]           r_armed;
    logic [KEYS-1:0]           r_led;
    logic                      r_pending;
    logic                      r_out_valid;
    logic [STATES_W-1:0]       r_key_states;
    logic [IO_KEYS-1:0]        r_led_lines;
    logic                      r_press_pending;

    t_key_state                n_state [KEYS];
    logic [CNT_W-1:0]          n_count [KEYS];
    logic [KEYS-1:0]           n_armed;
    logic [KEYS-1:0]           n_led;
    logic                      n_pending;

    logic                      w_in_acc;
    logic                      w_cfg_acc;
    logic [KEYS+IO_KEYS-1:0]   w_pin_ext;
    logic [KEYS+IO_KEYS-1:0]   w_fell_ext;
    logic [KEYS-1:0]           w_pin_low;
    logic [KEYS-1:0]           w_fell;
    logic [CNT_W-1:0]          w_settle_eff;
    logic [CNT_W-1:0]          w_recheck_eff;
    logic [2*(KEYS+IO_KEYS)-1:0] w_states_ext;
    logic [KEYS+IO_KEYS-1:0]   w_led_ext;
    logic [KEYS-1:0]           w_cnt_zero;
    logic [KEYS-1:0]           w_not_up;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid     = r_out_valid;
    assign o_key_states    = r_key_states;
    assign o_led_lines     = r_led_lines;
    assign o_press_pending = r_press_pending;

    // Keys without a pin never see an edge or a low level.
    assign w_pin_ext     = {{KEYS{1'b0}}, ~i_pin_levels};
    assign w_fell_ext    = {{KEYS{1'b0}}, i_falling_edges};
    assign w_pin_low     = w_pin_ext[KEYS-1:0];
    assign w_fell        = w_fell_ext[KEYS-1:0];
    assign w_settle_eff  = eff_delay(r_settle);
    assign w_recheck_eff = eff_delay(r_recheck);

    always_comb begin
        n_led     = r_led;
        n_pending = r_pending;
        if (i_read_strobe) begin
            n_led     = '0;
            n_pending = 1'b0;
        end
        for (int k = 0; k < KEYS; k++) begin
            n_state[k] = r_state[k];
            n_count[k] = r_count[k];
            n_armed[k] = r_armed[k];
            if (r_armed[k]) begin
                if (r_count[k] != '0) begin
                    n_count[k] = r_count[k] - CNT_W'(1);
                end
                if (n_count[k] == '0) begin
                    if (w_pin_low[k]) begin
                        if (r_state[k] == KEY_UNSURE) begin
                            n_state[k] = KEY_PRESSED;
                            n_led[k]   = 1'b1;
                            n_pending  = 1'b1;
                        end
                        n_count[k] = w_recheck_eff;
                    end else begin
                        n_state[k] = KEY_UP;
                        n_armed[k] = 1'b0;
                    end
                end
            end
            if (w_fell[k] && n_state[k] == KEY_UP) begin
                n_state[k] = KEY_UNSURE;
                n_count[k] = w_settle_eff;
                n_armed[k] = 1'b1;
            end
        end
    end

    always_comb begin
        w_states_ext = '0;
        w_led_ext    = '0;
        w_led_ext[KEYS-1:0] = n_led;
        for (int k = 0; k < KEYS; k++) begin
            w_states_ext[2*k +: 2] = n_state[k];
        end
    end

    always_comb begin
        for (int k = 0; k < KEYS; k++) begin
            w_cnt_zero[k] = (r_count[k] == '0);
            w_not_up[k]   = (r_state[k] != KEY_UP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle  <= SETTLE_RESET;
            r_recheck <= RECHECK_RESET;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                REG_SETTLE:  r_settle  <= i_cfg_data;
                REG_RECHECK: r_recheck <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEYS; k++) begin
                r_state[k] <= KEY_UP;
                r_count[k] <= '0;
            end
            r_armed   <= '0;
            r_led     <= '0;
            r_pending <= 1'b0;
        end else if (w_in_acc) begin
            for (int k = 0; k < KEYS; k++) begin
                r_state[k] <= n_state[k];
                r_count[k] <= n_count[k];
            end
            r_armed   <= n_armed;
            r_led     <= n_led;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_key_states    <= w_states_ext[STATES_W-1:0];
            r_led_lines     <= w_led_ext[IO_KEYS-1:0];
            r_press_pending <= n_pending;
        end
    end

    // An armed timer always holds a nonzero count between ticks.
    `MKTD_ASSERT_NOW(a_armed_nonzero, i_clk, i_rst_n, 1'b1, (r_armed & w_cnt_zero) == '0)
    // A key that is not up always has its timer running.
    `MKTD_ASSERT_NOW(a_not_up_armed, i_clk, i_rst_n, 1'b1, (w_not_up & ~r_armed) == '0)
    // A lit LED line implies a pending press.
    `MKTD_ASSERT_NOW(a_led_pending, i_clk, i_rst_n, r_led != '0, r_pending)
    // An accepted tick always leaves a result waiting.
    `MKTD_ASSERT_NEXT(a_result_after_tick, i_clk, i_rst_n, w_in_acc, r_out_valid)

endmodule
